// ===== hw/rtl/rspl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rspl_pkg
// shared constants and types for the periodic suffix lock detector
// ----------------------------------------------------------------------------
package rspl_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int REPEATS_DEF       = 3;

    localparam int STATE_W  = 32;
    localparam int PERIOD_W = 5;

    // tuser codes on the input side
    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_CLEAR   = 1'b1;

    // outcome of one period search
    typedef struct packed {
        logic                done;
        logic                found;
        logic [PERIOD_W-1:0] period;
    } scan_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rspl_hist_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rspl_hist_mem
// history store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module rspl_hist_mem #(
    parameter int DEPTH  = rspl_pkg::HISTORY_DEPTH_DEF + 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [rspl_pkg::STATE_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]            rd_addr_a,
    input  wire logic [ADDR_W-1:0]            rd_addr_b,
    output logic      [rspl_pkg::STATE_W-1:0] rd_data_a,
    output logic      [rspl_pkg::STATE_W-1:0] rd_data_b
);

    logic [rspl_pkg::STATE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rspl_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rspl_scan
// period search sequencer: one compare of x[j] against x[j-len] per cycle
// ----------------------------------------------------------------------------
module rspl_scan #(
    parameter int SLOTS   = rspl_pkg::HISTORY_DEPTH_DEF + 1,
    parameter int IDX_W   = $clog2(SLOTS),
    parameter int REPEATS = rspl_pkg::REPEATS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [IDX_W-1:0]             base,
    input  wire logic [IDX_W-1:0]             last,
    output logic      [IDX_W-1:0]             rd_addr_a,
    output logic      [IDX_W-1:0]             rd_addr_b,
    input  wire logic [rspl_pkg::STATE_W-1:0] rd_data_a,
    input  wire logic [rspl_pkg::STATE_W-1:0] rd_data_b,
    output rspl_pkg::scan_res_t               res
);

    localparam int SW = IDX_W + 5;
    localparam int PW = rspl_pkg::PERIOD_W;
    localparam logic [SW-1:0]    REP_W   = SW'(REPEATS);
    localparam logic [IDX_W:0]   SLOTS_W = (IDX_W + 1)'(SLOTS);
    localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

    logic                busy_reg, busy_next;
    logic [IDX_W-1:0]    base_reg, base_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic [IDX_W-1:0]    len_reg, len_next;
    logic [IDX_W-1:0]    span_reg, span_next;
    logic [IDX_W-1:0]    up_reg, up_next;
    logic [IDX_W-1:0]    lo_reg, lo_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic                issue_en_reg, issue_en_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                cmp_last_reg, cmp_last_next;
    rspl_pkg::scan_res_t res_reg, res_next;

    logic                mismatch;
    logic                hit;
    logic [SW-1:0]       span_wide;
    logic [IDX_W-1:0]    len_inc;
    logic [SW-1:0]       first_start;

    function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] b,
                                                 input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] sum;
        begin
            sum = {1'b0, b} + {1'b0, idx};
            if (sum >= SLOTS_W)
            begin
                sum = sum - SLOTS_W;
            end
            return sum[IDX_W-1:0];
        end
    endfunction

    assign rd_addr_a = to_phys(base_reg, up_reg);
    assign rd_addr_b = to_phys(base_reg, lo_reg);
    assign res       = res_reg;

    assign mismatch    = cmp_vld_reg && (rd_data_a != rd_data_b);
    assign hit         = cmp_vld_reg && !mismatch && cmp_last_reg;
    assign span_wide   = {5'b0, span_reg} + REP_W;
    assign len_inc     = len_reg + ONE_IDX;
    assign first_start = {5'b0, last} - REP_W;

    always_comb
    begin
        busy_next     = busy_reg;
        base_next     = base_reg;
        last_next     = last_reg;
        len_next      = len_reg;
        span_next     = span_reg;
        up_next       = up_reg;
        lo_next       = lo_reg;
        start_next    = start_reg;
        issue_en_next = issue_en_reg;
        cmp_vld_next  = 1'b0;
        cmp_last_next = cmp_last_reg;
        res_next      = '0;

        if (start)
        begin
            busy_next     = 1'b1;
            base_next     = base;
            last_next     = last;
            len_next      = ONE_IDX;
            span_next     = REP_W[IDX_W-1:0];
            up_next       = last;
            lo_next       = last - ONE_IDX;
            start_next    = first_start[IDX_W-1:0];
            issue_en_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                busy_next       = 1'b0;
                issue_en_next   = 1'b0;
                res_next.done   = 1'b1;
                res_next.found  = 1'b1;
                res_next.period = PW'(len_reg);
            end
            else if (mismatch)
            begin
                // next candidate period, or give up once it no longer fits
                if (span_wide > {5'b0, last_reg})
                begin
                    busy_next     = 1'b0;
                    issue_en_next = 1'b0;
                    res_next.done = 1'b1;
                end
                else
                begin
                    len_next      = len_inc;
                    span_next     = span_wide[IDX_W-1:0];
                    up_next       = last_reg;
                    lo_next       = last_reg - len_inc;
                    start_next    = last_reg - span_wide[IDX_W-1:0];
                    issue_en_next = 1'b1;
                end
            end
            else if (issue_en_reg)
            begin
                cmp_vld_next  = 1'b1;
                cmp_last_next = (lo_reg == start_reg);
                up_next       = up_reg - ONE_IDX;
                lo_next       = lo_reg - ONE_IDX;
                if (lo_reg == start_reg)
                begin
                    issue_en_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            issue_en_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            issue_en_reg <= issue_en_next;
            cmp_vld_reg  <= cmp_vld_next;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        last_reg     <= last_next;
        len_reg      <= len_next;
        span_reg     <= span_next;
        up_reg       <= up_next;
        lo_reg       <= lo_next;
        start_reg    <= start_next;
        cmp_last_reg <= cmp_last_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/repeated_suffix_period_lock_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// repeated_suffix_period_lock_core
// appends state words to a circular history and reports the smallest period
// that the newest entries repeat with
// ----------------------------------------------------------------------------
//  channel  direction  width  contents
//  s_*      in         32+1   tdata state_value, tuser func
//  m_*      out        8      tdata locked, period
//
// a clear or a short history goes from ST_IDLE through ST_DONE to m_tvalid
// without a search; an observe with REPEATS or more stored entries first runs
// a search in ST_SCAN, which moves to the next period at a mismatch and does
// one compare per cycle on the two read ports of the history.
// reset empties the history; memory contents are not cleared.
// one item is in work at a time; s_tready is low until the result has moved
// into the output register, which m_tready may stall freely.
// ----------------------------------------------------------------------------
module repeated_suffix_period_lock_core #(
    parameter int HISTORY_DEPTH = rspl_pkg::HISTORY_DEPTH_DEF,
    parameter int REPEATS       = rspl_pkg::REPEATS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [rspl_pkg::STATE_W-1:0] s_tdata,  // [31:0] state_value
    input  wire logic                         s_tuser,  // [0] func
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [7:0]                   m_tdata   // [0] locked, [5:1] period, [7:6] zero
);

    localparam int SLOTS = HISTORY_DEPTH + 1;
    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W:0]   SLOTS_W = (IDX_W + 1)'(SLOTS);
    localparam logic [IDX_W:0]   HD_W    = (IDX_W + 1)'(HISTORY_DEPTH);
    localparam logic [IDX_W+4:0] REP_W   = (IDX_W + 5)'(REPEATS);
    localparam logic [IDX_W-1:0] ONE_IDX = IDX_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                fill_reg, fill_next;
    logic [IDX_W-1:0]                base_reg, base_next;
    logic                            start_reg, start_next;
    logic                            res_locked_reg, res_locked_next;
    logic [rspl_pkg::PERIOD_W-1:0]   res_period_reg, res_period_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            out_locked_reg, out_locked_next;
    logic [rspl_pkg::PERIOD_W-1:0]   out_period_reg, out_period_next;

    logic                            in_acc;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [IDX_W:0]                  wr_sum;
    logic [IDX_W:0]                  wr_wrap;
    logic [IDX_W:0]                  n_full;
    logic [IDX_W:0]                  base_inc;
    logic [IDX_W-1:0]                base_adv;
    logic [IDX_W-1:0]                fill_after;
    logic                            do_search;
    logic [IDX_W-1:0]                rd_addr_a, rd_addr_b;
    logic [rspl_pkg::STATE_W-1:0]    rd_data_a, rd_data_b;
    rspl_pkg::scan_res_t             scan_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign wr_en    = in_acc && (s_tuser == rspl_pkg::FUNC_OBSERVE);

    // physical slot of the new entry
    assign wr_sum  = {1'b0, base_reg} + {1'b0, fill_reg};
    assign wr_wrap = wr_sum - SLOTS_W;
    assign wr_addr = (wr_sum >= SLOTS_W) ? wr_wrap[IDX_W-1:0] : wr_sum[IDX_W-1:0];

    // history bookkeeping when the new entry is kept without lock
    assign n_full     = {1'b0, fill_reg} + {1'b0, ONE_IDX};
    assign base_inc   = {1'b0, base_reg} + {1'b0, ONE_IDX};
    assign base_adv   = (base_inc >= SLOTS_W) ? '0 : base_inc[IDX_W-1:0];
    assign fill_after = (n_full > HD_W) ? HD_W[IDX_W-1:0] : n_full[IDX_W-1:0];
    assign do_search  = ({5'b0, fill_reg} >= REP_W);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        base_next       = base_reg;
        start_next      = 1'b0;
        res_locked_next = res_locked_reg;
        res_period_next = res_period_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_locked_next = out_locked_reg;
        out_period_next = out_period_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_locked_next = 1'b0;
                    res_period_next = '0;
                    if (s_tuser == rspl_pkg::FUNC_CLEAR)
                    begin
                        fill_next  = '0;
                        state_next = ST_DONE;
                    end
                    else if (do_search)
                    begin
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        fill_next  = fill_after;
                        if (n_full > HD_W)
                        begin
                            base_next = base_adv;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    res_locked_next = scan_res.found;
                    res_period_next = scan_res.period;
                    if (scan_res.found)
                    begin
                        fill_next = '0;
                    end
                    else
                    begin
                        fill_next = fill_after;
                        if (n_full > HD_W)
                        begin
                            base_next = base_adv;
                        end
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_locked_next = res_locked_reg;
                    out_period_next = res_period_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            base_reg     <= '0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            base_reg     <= base_next;
            start_reg    <= start_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_locked_reg <= res_locked_next;
        res_period_reg <= res_period_next;
        out_locked_reg <= out_locked_next;
        out_period_reg <= out_period_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_period_reg, out_locked_reg};

    rspl_hist_mem #(
        .DEPTH  (SLOTS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (s_tdata),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    rspl_scan #(
        .SLOTS   (SLOTS),
        .IDX_W   (IDX_W),
        .REPEATS (REPEATS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .base      (base_reg),
        .last      (fill_reg),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .res       (scan_res)
    );

    // a search only finishes while the control waits for it
    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> (state_reg == ST_SCAN))
        else $error("search result outside scan state");

    // history never holds more than its depth between transactions
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, fill_reg} <= HD_W) && ({1'b0, base_reg} < SLOTS_W))
        else $error("history fill or base out of range");

    // a clear gives no lock and empties the history
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == rspl_pkg::FUNC_CLEAR))
        |=> (state_reg == ST_DONE) && !res_locked_reg && (fill_reg == '0))
        else $error("clear transaction mishandled");

    // a new search starts only right after an observe accepted in the idle state
    a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> $past(state_reg == ST_IDLE) && (state_reg == ST_SCAN))
        else $error("search started outside an accepted observe");

endmodule

`default_nettype wire
